### hw/rtl/sspt_pkg.sv
// ----------------------------------------------------------------------------
// sspt_pkg - shared types and constants of the stepper speed pulse tracker
// Mode, direction and item kind codes, sequencer states and the fixed-point
// constants for the step period and the position scaling.
// ----------------------------------------------------------------------------
package sspt_pkg;

  // Step counter width (two's complement, wraps)
  localparam int STEP_BITS = 32;

  // Channel payload widths
  localparam int IN_DATA_W  = 24;  // drive_speed, reset_request, zero fill
  localparam int IN_USER_W  = 2;   // kind
  localparam int OUT_DATA_W = 24;  // position_mm .. mode, zero fill

  // Period numerator and divider geometry
  localparam int              PERIOD_W   = 12;
  localparam logic [PERIOD_W-1:0] PERIOD_NUM = PERIOD_W'(2535);
  localparam int              SPEED_W    = 16;

  // Position scaling, Q16
  localparam int              SCALE_W        = 15;
  localparam logic [SCALE_W-1:0] DRIVE_SCALE_Q16 = SCALE_W'(17594);
  localparam logic [SCALE_W-1:0] STOP_SCALE_Q16  = SCALE_W'(16613);
  localparam int              PROD_W         = 32;
  localparam int              POS_W          = 16;

  // Report distance in steps
  localparam int REPORT_STEPS = 40;

  // Shared iteration counter
  localparam int CNT_W = 4;
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(PERIOD_W - 1);
  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(SCALE_W - 1);

  // Item kinds
  localparam logic [1:0] KIND_CMD  = 2'd0;
  localparam logic [1:0] KIND_TICK = 2'd1;
  localparam logic [1:0] KIND_ACK  = 2'd2;

  typedef enum logic [1:0] {
    MODE_RESET = 2'd0,
    MODE_STOP  = 2'd1,
    MODE_DRIVE = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    DIR_STOPPED  = 2'd0,
    DIR_FORWARD  = 2'd1,
    DIR_BACKWARD = 2'd2
  } dir_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_CHK  = 5'b00100,
    ST_MUL  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

endpackage

### hw/rtl/stepper_speed_pulse_tracker_unit.sv
// ----------------------------------------------------------------------------
// stepper_speed_pulse_tracker_unit - step pulse generator with position report
// Turns speed commands and timer ticks into step pin toggles, tracks the
// signed step count and reports the travelled distance in millimeters.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one item per transfer. in_tuser holds the item kind (command,
//           timer tick, acknowledge); in_tdata holds the signed speed and
//           the reset request bit of a command.
//   out_* : exactly one result per input item, in input order, holding the
//           position in mm, step pin status, direction, report flag and mode.
//   Sequence: a command with nonzero speed runs a restoring divider for the
//   step period, one quotient bit per cycle; every item then runs a
//   shift-and-add multiply for the position, one scale bit per cycle, and
//   the result is registered for output.
//   Items are taken one at a time; in_tready is high only when idle, so a
//   new item is not accepted until the previous result has been transferred.
//   Reset: rst_n clears the control state: reset mode, direction stopped, counts 0.
//   Stall: a result waits in the output register until out_tready; no new
//   item is taken until it has been transferred.
// ----------------------------------------------------------------------------
module stepper_speed_pulse_tracker_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [15:0] drive_speed (signed), [16] reset_request, [23:17] zero
  input  logic [sspt_pkg::IN_DATA_W-1:0]   in_tdata,
  // [1:0] kind
  input  logic [sspt_pkg::IN_USER_W-1:0]   in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [15:0] position_mm (signed), [16] step_toggle, [17] step_level,
  // [18] direction_forward, [19] report_flag, [21:20] mode, [23:22] zero
  output logic [sspt_pkg::OUT_DATA_W-1:0]  out_tdata
);

  import sspt_pkg::*;

  // Control and state registers
  state_t                state_r, state_nxt;
  mode_t                 mode_r, mode_nxt;
  dir_t                  dir_r, dir_nxt;
  logic [PERIOD_W-1:0]   period_r, period_nxt;
  logic [PERIOD_W-1:0]   tick_r, tick_nxt;
  logic [STEP_BITS-1:0]  step_r, step_nxt;
  logic [STEP_BITS-1:0]  last_r, last_nxt;
  logic                  pending_r, pending_nxt;
  logic                  armed_r, armed_nxt;
  logic                  pin_r, pin_nxt;
  logic                  toggle_r, toggle_nxt;
  logic                  stepped_r, stepped_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;

  // Datapath registers of the shared divider / multiplier
  logic [SPEED_W-1:0]    divisor_r, divisor_nxt;
  logic [SPEED_W-1:0]    rem_r, rem_nxt;
  logic [PERIOD_W-1:0]   dvd_r, dvd_nxt;
  logic [PROD_W-1:0]     acc_r, acc_nxt;
  logic [PROD_W-1:0]     mcand_r, mcand_nxt;
  logic [SCALE_W-1:0]    scale_r, scale_nxt;
  logic                  neg_r, neg_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // Combinational helpers
  logic [1:0]              kind;
  logic signed [SPEED_W-1:0] speed;
  logic                    rst_req;
  logic [SPEED_W-1:0]      speed_mag;
  logic [PERIOD_W-1:0]     tick_inc;
  logic [SPEED_W:0]        trial;
  logic                    trial_ge;
  logic signed [STEP_BITS:0] diff;
  logic [STEP_BITS-1:0]    step_mag;
  logic [PROD_W-1:0]       acc_sum;
  logic [POS_W-1:0]        prod_hi;
  logic [POS_W-1:0]        pos;

  assign kind      = in_tuser[1:0];
  assign speed     = $signed(in_tdata[SPEED_W-1:0]);
  assign rst_req   = in_tdata[SPEED_W];
  assign speed_mag = speed[SPEED_W-1] ? SPEED_W'(-speed) : SPEED_W'(speed);
  assign tick_inc  = tick_r + PERIOD_W'(1);

  // Divider step: shift in the next dividend bit and try a subtract
  assign trial    = {rem_r, dvd_r[PERIOD_W-1]};
  assign trial_ge = trial >= {1'b0, divisor_r};

  // Signed distance since the last report
  assign diff = $signed({step_r[STEP_BITS-1], step_r}) -
                $signed({last_r[STEP_BITS-1], last_r});

  assign step_mag = step_r[STEP_BITS-1] ? -step_r : step_r;

  // Multiplier step: final accumulator and scaled position
  assign acc_sum = scale_r[0] ? acc_r + mcand_r : acc_r;
  assign prod_hi = acc_sum[PROD_W-1:PROD_W-POS_W];
  assign pos     = (mode_r == MODE_RESET) ? '0 : (neg_r ? -prod_hi : prod_hi);

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata  = out_data_r;

  // Sequencer and state update
  always_comb begin
    state_nxt    = state_r;
    mode_nxt     = mode_r;
    dir_nxt      = dir_r;
    period_nxt   = period_r;
    tick_nxt     = tick_r;
    step_nxt     = step_r;
    last_nxt     = last_r;
    pending_nxt  = pending_r;
    armed_nxt    = armed_r;
    pin_nxt      = pin_r;
    toggle_nxt   = toggle_r;
    stepped_nxt  = stepped_r;
    cnt_nxt      = cnt_r;
    divisor_nxt  = divisor_r;
    rem_nxt      = rem_r;
    dvd_nxt      = dvd_r;
    acc_nxt      = acc_r;
    mcand_nxt    = mcand_r;
    scale_nxt    = scale_r;
    neg_nxt      = neg_r;
    out_data_nxt = out_data_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          toggle_nxt  = 1'b0;
          stepped_nxt = 1'b0;
          state_nxt   = ST_CHK;
          case (kind)
            KIND_CMD: begin
              if (speed == '0) begin
                mode_nxt = MODE_STOP;
                if (rst_req) begin
                  step_nxt  = '0;
                  last_nxt  = '0;
                  armed_nxt = 1'b1;
                  mode_nxt  = MODE_RESET;
                end
              end else begin
                // Start the period division
                mode_nxt    = MODE_DRIVE;
                dir_nxt     = speed[SPEED_W-1] ? DIR_BACKWARD : DIR_FORWARD;
                divisor_nxt = speed_mag;
                rem_nxt     = '0;
                dvd_nxt     = PERIOD_NUM;
                cnt_nxt     = '0;
                state_nxt   = ST_DIV;
              end
            end
            KIND_TICK: begin
              if (mode_r == MODE_DRIVE) begin
                if (tick_inc >= period_r && dir_r != DIR_STOPPED) begin
                  pin_nxt     = ~pin_r;
                  toggle_nxt  = 1'b1;
                  stepped_nxt = 1'b1;
                  tick_nxt    = '0;
                  if (dir_r == DIR_FORWARD) begin
                    step_nxt = step_r + STEP_BITS'(1);
                  end else begin
                    step_nxt = step_r - STEP_BITS'(1);
                  end
                end else begin
                  tick_nxt = tick_inc;
                end
              end else if (mode_r == MODE_RESET && armed_r) begin
                armed_nxt   = 1'b0;
                pending_nxt = 1'b1;
              end
            end
            KIND_ACK: begin
              pending_nxt = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end

      ST_DIV: begin
        // One quotient bit per cycle, shifted into the period register
        if (trial_ge) begin
          rem_nxt = SPEED_W'(trial - {1'b0, divisor_r});
        end else begin
          rem_nxt = trial[SPEED_W-1:0];
        end
        dvd_nxt    = {dvd_r[PERIOD_W-2:0], 1'b0};
        period_nxt = {period_r[PERIOD_W-2:0], trial_ge};
        cnt_nxt    = cnt_r + CNT_W'(1);
        if (cnt_r == DIV_LAST) begin
          state_nxt = ST_CHK;
        end
      end

      ST_CHK: begin
        // Raise a report after enough travel in the driving direction
        if (stepped_r) begin
          if ((dir_r == DIR_FORWARD && diff >= (STEP_BITS+1)'(REPORT_STEPS)) ||
              (dir_r == DIR_BACKWARD && diff <= -(STEP_BITS+1)'(REPORT_STEPS))) begin
            last_nxt    = step_r;
            pending_nxt = 1'b1;
          end
        end
        // Load the multiplier with the step magnitude and scale
        neg_nxt   = step_r[STEP_BITS-1];
        mcand_nxt = PROD_W'(step_mag);
        acc_nxt   = '0;
        scale_nxt = (mode_r == MODE_DRIVE) ? DRIVE_SCALE_Q16 : STOP_SCALE_Q16;
        cnt_nxt   = '0;
        state_nxt = ST_MUL;
      end

      ST_MUL: begin
        // One scale bit per cycle
        acc_nxt   = acc_sum;
        mcand_nxt = {mcand_r[PROD_W-2:0], 1'b0};
        scale_nxt = {1'b0, scale_r[SCALE_W-1:1]};
        cnt_nxt   = cnt_r + CNT_W'(1);
        if (cnt_r == MUL_LAST) begin
          out_data_nxt = {2'b00, mode_r, pending_r, (dir_r == DIR_FORWARD),
                          pin_r, toggle_r, pos};
          state_nxt    = ST_OUT;
        end
      end

      ST_OUT: begin
        // Hold the result until the transfer completes
        if (out_tready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      mode_r    <= MODE_RESET;
      dir_r     <= DIR_STOPPED;
      period_r  <= '0;
      tick_r    <= '0;
      step_r    <= '0;
      last_r    <= '0;
      pending_r <= 1'b0;
      armed_r   <= 1'b0;
      pin_r     <= 1'b0;
      toggle_r  <= 1'b0;
      stepped_r <= 1'b0;
      cnt_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      mode_r    <= mode_nxt;
      dir_r     <= dir_nxt;
      period_r  <= period_nxt;
      tick_r    <= tick_nxt;
      step_r    <= step_nxt;
      last_r    <= last_nxt;
      pending_r <= pending_nxt;
      armed_r   <= armed_nxt;
      pin_r     <= pin_nxt;
      toggle_r  <= toggle_nxt;
      stepped_r <= stepped_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    divisor_r  <= divisor_nxt;
    rem_r      <= rem_nxt;
    dvd_r      <= dvd_nxt;
    acc_r      <= acc_nxt;
    mcand_r    <= mcand_nxt;
    scale_r    <= scale_nxt;
    neg_r      <= neg_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
